[hdl/elfhc_pkg.sv]
// ----------------------------------------------------------------------------
// elfhc_pkg
// Shared types, codes and constants of the elf32 header checker.
// ----------------------------------------------------------------------------
package elfhc_pkg;

    localparam int unsigned ID_W     = 5;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned OFFSET_W = 6;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [OFFSET_W-1:0] OFF_CLASS    = 6'd4;
    localparam logic [OFFSET_W-1:0] OFF_DATA     = 6'd5;
    localparam logic [OFFSET_W-1:0] OFF_IDENTVER = 6'd6;
    localparam logic [OFFSET_W-1:0] OFF_OSABI    = 6'd7;
    localparam logic [OFFSET_W-1:0] OFF_ABIVER   = 6'd8;
    localparam logic [OFFSET_W-1:0] OFF_PAD_END  = 6'd15;
    localparam logic [OFFSET_W-1:0] OFF_MACHINE  = 6'd18;
    localparam logic [OFFSET_W-1:0] OFF_VERSION  = 6'd20;
    localparam logic [OFFSET_W-1:0] OFF_HALF2    = 6'd40;
    localparam logic [OFFSET_W-1:0] HDR_BYTES    = 6'd52;

    localparam logic [7:0] MAG0 = 8'd127;
    localparam logic [7:0] MAG1 = 8'd69;
    localparam logic [7:0] MAG2 = 8'd76;
    localparam logic [7:0] MAG3 = 8'd70;

    localparam logic [ID_W-1:0] FID_CLASS    = 5'd0;
    localparam logic [ID_W-1:0] FID_DATA     = 5'd1;
    localparam logic [ID_W-1:0] FID_IDENTVER = 5'd2;
    localparam logic [ID_W-1:0] FID_OSABI    = 5'd3;
    localparam logic [ID_W-1:0] FID_ABIVER   = 5'd4;
    localparam logic [ID_W-1:0] FID_TYPE     = 5'd5;
    localparam logic [ID_W-1:0] FID_MACHINE  = 5'd6;
    localparam logic [ID_W-1:0] FID_VERSION  = 5'd7;
    localparam logic [ID_W-1:0] FID_EHSIZE   = 5'd12;
    localparam logic [ID_W-1:0] FID_SHSTRNDX = 5'd17;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 4'd0,
        ST_MAGIC    = 4'd1,
        ST_CLASS    = 4'd2,
        ST_DATA     = 4'd3,
        ST_IDENTVER = 4'd4,
        ST_OSABI    = 4'd5,
        ST_PADDING  = 4'd6,
        ST_VERSION  = 4'd7,
        ST_CLASS64  = 4'd8
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]    field_id;
        logic [VALUE_W-1:0] field_value;
        status_t            status;
        logic               last;
    } result_t;

    function automatic logic abi_known(input logic [7:0] b);
        case (b)
            8'd0, 8'd1, 8'd2, 8'd3, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
            8'd11, 8'd12, 8'd64, 8'd97, 8'd255: abi_known = 1'b1;
            default: abi_known = 1'b0;
        endcase
    endfunction

endpackage

[hdl/elf32_header_checker_core.sv]
// ----------------------------------------------------------------------------
// elf32_header_checker_core
// ELF32 file header checker: checks ident bytes and e_version, emits assembled fields.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one header byte per word, tuser set on offset 0 of a header
//   m_axis: one word per completed field or per failed check
//   tlast marks the final word of a header (error, class64 stop, shstrndx)
// output
//   a result word is registered, valid in the cycle after the byte that completes it
// throughput
//   one byte per cycle; s_axis_tready drops only while a result word
//   waits in the output register and m_axis_tready is low
// reset
//   the checker waits for a byte with tuser set; bytes before that are
//   dropped, and bytes after a final word are dropped until the next start
// stall
//   a held result keeps tdata and tlast stable; bytes that give no result
//   are still taken as long as the output register can be loaded
// ----------------------------------------------------------------------------
module elf32_header_checker_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // data_byte
    input  logic                                 s_axis_tuser,  // start_of_header
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [elfhc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // field_id, field_value, status, zero fill
    output logic                                 m_axis_tlast
);
    import elfhc_pkg::*;

    logic    fire;
    logic    load_ok;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign s_axis_tready = load_ok;
    assign fire          = s_axis_tvalid && load_ok;

    elfhc_step u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .data_byte       (s_axis_tdata),
        .start_of_header (s_axis_tuser),
        .res_valid       (res_valid),
        .res             (res)
    );

    elfhc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.status, out_res.field_value, out_res.field_id};
    assign m_axis_tlast = out_res.last;

endmodule

[hdl/elfhc_step.sv]
// ----------------------------------------------------------------------------
// elfhc_step
// Header state registers and the per-byte check and field assembly logic.
// ----------------------------------------------------------------------------
module elfhc_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic [7:0]              data_byte,
    input  logic                    start_of_header,
    output logic                    res_valid,
    output elfhc_pkg::result_t      res
);
    import elfhc_pkg::*;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                halted_reg, halted_next;
    logic                class64_reg, class64_next;

    always_comb
    begin
        logic [OFFSET_W-1:0] o;
        logic [OFFSET_W-1:0] rel;
        logic [VALUE_W-1:0]  acc_eff;
        logic [VALUE_W-1:0]  acc_ins;
        logic                halted_eff;
        logic [1:0]          pos;
        logic                done;
        logic [ID_W-1:0]     fid;

        o          = start_of_header ? '0 : offset_reg;
        acc_eff    = start_of_header ? '0 : acc_reg;
        halted_eff = start_of_header ? 1'b0 : halted_reg;
        rel        = '0;
        pos        = '0;
        done       = 1'b0;
        fid        = FID_TYPE;
        acc_ins    = '0;

        offset_next  = o;
        acc_next     = acc_eff;
        halted_next  = halted_eff;
        class64_next = start_of_header ? 1'b0 : class64_reg;
        res_valid    = 1'b0;
        res          = '{field_id: '0, field_value: '0, status: ST_OK, last: 1'b0};

        if (!halted_eff)
        begin
            offset_next = o + 6'd1;
            if (o < OFF_CLASS)
            begin
                if ((o == 6'd0 && data_byte != MAG0) || (o == 6'd1 && data_byte != MAG1) ||
                    (o == 6'd2 && data_byte != MAG2) || (o == 6'd3 && data_byte != MAG3))
                begin
                    res_valid  = 1'b1;
                    res.status = ST_MAGIC;
                    res.last   = 1'b1;
                end
            end
            else if (o == OFF_CLASS)
            begin
                res_valid = 1'b1;
                if (data_byte != 8'd1 && data_byte != 8'd2)
                begin
                    res.status = ST_CLASS;
                    res.last   = 1'b1;
                end
                else
                begin
                    class64_next    = (data_byte == 8'd2);
                    res.field_id    = FID_CLASS;
                    res.field_value = {24'd0, data_byte};
                end
            end
            else if (o == OFF_DATA)
            begin
                res_valid = 1'b1;
                if (data_byte != 8'd1 && data_byte != 8'd2)
                begin
                    res.status = ST_DATA;
                    res.last   = 1'b1;
                end
                else
                begin
                    res.field_id    = FID_DATA;
                    res.field_value = {24'd0, data_byte};
                end
            end
            else if (o == OFF_IDENTVER)
            begin
                res_valid = 1'b1;
                if (data_byte == 8'd0)
                begin
                    res.status = ST_IDENTVER;
                    res.last   = 1'b1;
                end
                else
                begin
                    res.field_id    = FID_IDENTVER;
                    res.field_value = {24'd0, data_byte};
                end
            end
            else if (o == OFF_OSABI)
            begin
                res_valid = 1'b1;
                if (!abi_known(data_byte))
                begin
                    res.status = ST_OSABI;
                    res.last   = 1'b1;
                end
                else
                begin
                    res.field_id    = FID_OSABI;
                    res.field_value = {24'd0, data_byte};
                end
            end
            else if (o == OFF_ABIVER)
            begin
                res_valid       = 1'b1;
                res.field_id    = FID_ABIVER;
                res.field_value = {24'd0, data_byte};
            end
            else if (o < OFF_PAD_END)
            begin
                if (data_byte != 8'd0)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_PADDING;
                    res.last   = 1'b1;
                end
            end
            else if (o == OFF_PAD_END)
            begin
                res_valid = 1'b0;
            end
            else if (o >= HDR_BYTES)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                // field position and id from the byte offset
                if (o < OFF_MACHINE)
                begin
                    fid  = FID_TYPE;
                    pos  = {1'b0, o[0]};
                    done = o[0];
                end
                else if (o < OFF_VERSION)
                begin
                    fid  = FID_MACHINE;
                    pos  = {1'b0, o[0]};
                    done = o[0];
                end
                else if (o < OFF_HALF2)
                begin
                    rel  = o - OFF_VERSION;
                    fid  = FID_VERSION + {2'd0, rel[4:2]};
                    pos  = rel[1:0];
                    done = (rel[1:0] == 2'd3);
                end
                else
                begin
                    rel  = o - OFF_HALF2;
                    fid  = FID_EHSIZE + {2'd0, rel[3:1]};
                    pos  = {1'b0, rel[0]};
                    done = rel[0];
                end

                acc_ins = {24'd0, data_byte} << {pos, 3'd0};
                if (pos == 2'd0)
                    acc_next = acc_ins;
                else
                    acc_next = acc_eff | acc_ins;

                if (done)
                begin
                    res_valid       = 1'b1;
                    res.field_id    = fid;
                    res.field_value = acc_next;
                    if (fid == FID_VERSION && acc_next == '0)
                    begin
                        res.field_id    = FID_CLASS;
                        res.field_value = '0;
                        res.status      = ST_VERSION;
                        res.last        = 1'b1;
                    end
                    else if (fid == FID_VERSION && class64_next)
                    begin
                        res.status = ST_CLASS64;
                        res.last   = 1'b1;
                    end
                    else if (fid == FID_SHSTRNDX)
                    begin
                        res.last = 1'b1;
                    end
                end
            end

            if (res_valid && res.last)
                halted_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            acc_reg     <= '0;
            halted_reg  <= 1'b1;
            class64_reg <= 1'b0;
        end
        else if (fire)
        begin
            offset_reg  <= offset_next;
            acc_reg     <= acc_next;
            halted_reg  <= halted_next;
            class64_reg <= class64_next;
        end
    end

endmodule

[hdl/elfhc_out_stage.sv]
// ----------------------------------------------------------------------------
// elfhc_out_stage
// Result register between the checker logic and the output stream.
// ----------------------------------------------------------------------------
module elfhc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                res_valid,
    input  elfhc_pkg::result_t  res,
    output logic                load_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output elfhc_pkg::result_t  out_res
);
    import elfhc_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // free slot, or the waiting word leaves this cycle
    assign load_ok   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
